// ----- hdl/xcrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared types, protocol characters and result codes.
// ----------------------------------------------------------------------------
package xcrc_pkg;

    localparam int RES_MAX = 5;             // most results one request can cause
    localparam int CNT_W   = 3;             // holds 0..RES_MAX

    localparam logic [10:0] LONG_BLOCK_BYTES  = 11'd1024;
    localparam logic [10:0] SHORT_BLOCK_BYTES = 11'd128;

    // Protocol characters
    localparam logic [7:0] C_SOH     = 8'h01;
    localparam logic [7:0] C_STX     = 8'h02;
    localparam logic [7:0] C_EOT     = 8'h04;
    localparam logic [7:0] C_ACK     = 8'h06;
    localparam logic [7:0] C_NAK     = 8'h15;
    localparam logic [7:0] C_CAN     = 8'h18;
    localparam logic [7:0] C_CRC_REQ = 8'h43;

    // Configuration register indexes
    localparam int          CFG_IDX_W            = 1;
    localparam logic [0:0]  CFG_RETRIES_AT_START = 1'b0;
    localparam logic [0:0]  CFG_RETRIES_AFTER_OK = 1'b1;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        K_SEND     = 3'd0,
        K_DATA     = 3'd1,
        K_ACCEPT   = 3'd2,
        K_DISCARD  = 3'd3,
        K_COMPLETE = 3'd4,
        K_ABORT    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_SEQ    = 3'd2,
        PH_COMPL  = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRCH   = 3'd5,
        PH_CRCL   = 3'd6,
        PH_FLUSH  = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] retries_at_start;
        logic [7:0] retries_after_good;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [7:0]  data_byte;
        logic [9:0]  data_index;
        logic [10:0] packet_length;
    } result_t;

    // Result list of one request; entry 0 goes out first.
    typedef struct packed {
        result_t [RES_MAX-1:0] ents;
        logic    [CNT_W-1:0]   cnt;
    } burst_t;

endpackage

// ----- hdl/xcrc_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC protocol engine
// Holds the receiver state and turns one request into its result list.
// ----------------------------------------------------------------------------
module xcrc_engine
    import xcrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  op_t        op,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output burst_t     burst
);

    phase_t      phase_reg,       phase_next;
    logic [7:0]  exp_seq_reg,     exp_seq_next;
    logic [7:0]  retries_reg,     retries_next;
    logic [7:0]  reply_reg,       reply_next;
    logic [10:0] pos_reg,         pos_next;
    logic        long_reg,        long_next;
    logic [7:0]  seq_reg,         seq_next;
    logic [7:0]  compl_reg,       compl_next;
    logic [15:0] crc_reg,         crc_next;
    logic [7:0]  crc_high_reg,    crc_high_next;

    logic        in_packet;
    logic [7:0]  retries_dec;
    logic [10:0] pos_inc;
    logic [10:0] blen;
    logic        pkt_ok;
    logic        is_dup;
    logic        is_good;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic result_t mk_res(input kind_t k, input logic [7:0] tx,
                                       input logic [7:0] db, input logic [9:0] idx,
                                       input logic [10:0] len);
        result_t r;
        r.kind          = k;
        r.tx_byte       = tx;
        r.data_byte     = db;
        r.data_index    = idx;
        r.packet_length = len;
        return r;
    endfunction

    assign in_packet   = (phase_reg == PH_SEQ) || (phase_reg == PH_COMPL) ||
                         (phase_reg == PH_DATA) || (phase_reg == PH_CRCH) ||
                         (phase_reg == PH_CRCL);
    assign retries_dec = retries_reg - 8'd1;
    assign pos_inc     = pos_reg + 11'd1;
    assign blen        = long_reg ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
    assign pkt_ok      = (seq_reg == ~compl_reg) && ({crc_high_reg, rx_byte} == crc_reg);
    assign is_dup      = pkt_ok && (seq_reg == exp_seq_reg - 8'd1);
    assign is_good     = pkt_ok && !is_dup && (seq_reg == exp_seq_reg);

    // Next state
    always_comb begin
        phase_next    = phase_reg;
        exp_seq_next  = exp_seq_reg;
        retries_next  = retries_reg;
        reply_next    = reply_reg;
        pos_next      = pos_reg;
        long_next     = long_reg;
        seq_next      = seq_reg;
        compl_next    = compl_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        if (accept) begin
            case (op)
                OP_START: begin
                    phase_next   = PH_HEADER;
                    exp_seq_next = 8'd1;
                    retries_next = cfg.retries_at_start;
                    reply_next   = C_CRC_REQ;
                    pos_next     = '0;
                end
                OP_BYTE: begin
                    case (phase_reg)
                        PH_HEADER: begin
                            if (rx_byte == C_STX || rx_byte == C_SOH) begin
                                long_next  = (rx_byte == C_STX);
                                phase_next = PH_SEQ;
                            end else if (rx_byte == C_EOT) begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_SEQ: begin
                            seq_next   = rx_byte;
                            phase_next = PH_COMPL;
                        end
                        PH_COMPL: begin
                            compl_next = rx_byte;
                            crc_next   = '0;
                            pos_next   = '0;
                            phase_next = PH_DATA;
                        end
                        PH_DATA: begin
                            crc_next = crc_update(crc_reg, rx_byte);
                            pos_next = pos_inc;
                            if (pos_inc >= blen) begin
                                phase_next = PH_CRCH;
                            end
                        end
                        PH_CRCH: begin
                            crc_high_next = rx_byte;
                            phase_next    = PH_CRCL;
                        end
                        PH_CRCL: begin
                            if (is_dup) begin
                                reply_next = C_ACK;
                                phase_next = PH_HEADER;
                            end else if (is_good) begin
                                exp_seq_next = exp_seq_reg + 8'd1;
                                retries_next = cfg.retries_after_good;
                                reply_next   = C_ACK;
                                phase_next   = PH_HEADER;
                            end else begin
                                reply_next = C_NAK;
                                phase_next = PH_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_TIMEOUT: begin
                    if (phase_reg != PH_IDLE) begin
                        retries_next = retries_dec;
                        phase_next   = (retries_dec == 8'd0) ? PH_IDLE : PH_HEADER;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result list
    always_comb begin
        logic [CNT_W-1:0] n;
        burst = '0;
        n     = '0;
        case (op)
            OP_START: begin
                if (in_packet) begin
                    burst.ents[n] = mk_res(K_DISCARD, '0, '0, '0, '0);
                    n = n + 3'd1;
                end
                burst.ents[n] = mk_res(K_SEND, C_CRC_REQ, '0, '0, '0);
                n = n + 3'd1;
            end
            OP_BYTE: begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (rx_byte == C_EOT) begin
                            burst.ents[0] = mk_res(K_SEND, C_ACK, '0, '0, '0);
                            burst.ents[1] = mk_res(K_SEND, C_ACK, '0, '0, '0);
                            burst.ents[2] = mk_res(K_COMPLETE, '0, '0, '0, '0);
                            n = 3'd3;
                        end
                    end
                    PH_DATA: begin
                        burst.ents[0] = mk_res(K_DATA, '0, rx_byte, pos_reg[9:0], '0);
                        n = 3'd1;
                    end
                    PH_CRCL: begin
                        if (is_dup) begin
                            burst.ents[0] = mk_res(K_DISCARD, '0, '0, '0, '0);
                            burst.ents[1] = mk_res(K_SEND, C_ACK, '0, '0, '0);
                            n = 3'd2;
                        end else if (is_good) begin
                            burst.ents[0] = mk_res(K_ACCEPT, '0, '0, '0, blen);
                            burst.ents[1] = mk_res(K_SEND, C_ACK, '0, '0, '0);
                            n = 3'd2;
                        end else begin
                            burst.ents[0] = mk_res(K_DISCARD, '0, '0, '0, '0);
                            n = 3'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_TIMEOUT: begin
                if (phase_reg != PH_IDLE) begin
                    if (in_packet) begin
                        burst.ents[n] = mk_res(K_DISCARD, '0, '0, '0, '0);
                        n = n + 3'd1;
                    end
                    if (retries_dec == 8'd0) begin
                        burst.ents[n] = mk_res(K_SEND, C_CAN, '0, '0, '0);
                        n = n + 3'd1;
                        burst.ents[n] = mk_res(K_SEND, C_CAN, '0, '0, '0);
                        n = n + 3'd1;
                        burst.ents[n] = mk_res(K_SEND, C_CAN, '0, '0, '0);
                        n = n + 3'd1;
                        burst.ents[n] = mk_res(K_ABORT, '0, '0, '0, '0);
                        n = n + 3'd1;
                    end else begin
                        burst.ents[n] = mk_res(K_SEND, reply_reg, '0, '0, '0);
                        n = n + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        burst.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            exp_seq_reg  <= 8'd1;
            retries_reg  <= 8'd15;
            reply_reg    <= C_CRC_REQ;
            pos_reg      <= '0;
            long_reg     <= 1'b0;
            seq_reg      <= '0;
            compl_reg    <= '0;
            crc_reg      <= '0;
            crc_high_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            exp_seq_reg  <= exp_seq_next;
            retries_reg  <= retries_next;
            reply_reg    <= reply_next;
            pos_reg      <= pos_next;
            long_reg     <= long_next;
            seq_reg      <= seq_next;
            compl_reg    <= compl_next;
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
        end
    end

endmodule

// ----- hdl/xmodem_crc_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver
// Receive side of XMODEM-CRC with 128- and 1024-byte blocks.
// ----------------------------------------------------------------------------
// Path: the result list is loaded into the result queue, then the output register.
// Throughput: one request per cycle while each causes at most one result and
//   m_tready stays high; a request with N results holds s_tready low until
//   its result queue is down to the last entry.
// Reset: aresetn is synchronous, active low; it clears the protocol state,
//   the result queue, the output valid flag and restores the retry budgets.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver
    import xcrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,

    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic [1:0]           s_tuser,   // [1:0] op

    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [7:0] tx_byte, [15:8] data_byte,
                                            // [25:16] data_index,
                                            // [36:26] packet_length, [39:37] zero
    output logic [2:0]           m_tuser,   // [2:0] kind
    output logic                 m_tlast
);

    cfg_t             cfg_reg;
    burst_t           burst;
    burst_t           q_reg,      q_next;
    logic             m_valid_reg, m_valid_next;
    result_t          m_res_reg,  m_res_next;
    logic             m_last_reg, m_last_next;

    logic             s_accept;
    logic             pop;

    // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retries_at_start   <= 8'd15;
            cfg_reg.retries_after_good <= 8'd10;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RETRIES_AT_START: cfg_reg.retries_at_start   <= cfg_wdata;
                CFG_RETRIES_AFTER_OK: cfg_reg.retries_after_good <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Protocol engine: state update and result list in one pass.
    xcrc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .op      (op_t'(s_tuser)),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .burst   (burst)
    );

    // Move the queue head into the output register when that register is
    // empty or being drained.
    assign pop = (q_reg.cnt != '0) && (!m_valid_reg || m_tready);

    // Take a new request once the queue is empty or its last entry leaves now;
    // with an entry queued, s_tready follows m_tready through pop.
    assign s_tready = (q_reg.cnt == '0) || ((q_reg.cnt == CNT_W'(1)) && pop);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        q_next = q_reg;
        if (s_accept) begin
            // old contents are gone or leave this cycle: load the new list
            q_next = burst;
        end else if (pop) begin
            // advance: drop the head, shift the rest down
            q_next.ents = q_reg.ents >> $bits(result_t);
            q_next.cnt  = q_reg.cnt - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_last_next  = m_last_reg;
        if (pop) begin
            m_valid_next = 1'b1;
            m_res_next   = q_reg.ents[0];
            m_last_next  = (q_reg.cnt == CNT_W'(1));
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.cnt   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            q_reg.cnt   <= q_next.cnt;
            m_valid_reg <= m_valid_next;
        end
        // Queue entries need no reset.
        q_reg.ents <= q_next.ents;
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.packet_length, m_res_reg.data_index,
                       m_res_reg.data_byte, m_res_reg.tx_byte};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_last_reg;

endmodule

// ----- hdl/xcrc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver port checker
// Watches the top-level ports and flags protocol or result slips.
// ----------------------------------------------------------------------------
module xcrc_checker
    import xcrc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Output register empties on reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A payload byte is always the only result of its request.
    a_data_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == K_DATA) |-> m_tlast)
        else $error("data byte not last");

    // An accepted packet reports one of the two block sizes.
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == K_ACCEPT) |->
            (m_tdata[36:26] == SHORT_BLOCK_BYTES) || (m_tdata[36:26] == LONG_BLOCK_BYTES))
        else $error("bad packet length");

    // Transfer complete and abort close the request's result list.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == K_COMPLETE) || (m_tuser == K_ABORT)) |-> m_tlast)
        else $error("end of transfer not last");

endmodule

bind xmodem_crc_receiver xcrc_checker u_xcrc_checker (.*);

// ----- test/tb_xmodem_crc_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver testbench
// A clocked driver sends start, byte and timeout requests and a clocked
// monitor takes the results. An in-bench model of the receiver predicts the
// results of every accepted request. The run starts with a short directed
// part. Random sessions follow: mostly well-formed packets with random
// payload, with corrupted, repeated and cut-off packets mixed in. Each side
// idles at random. The run goes through several retry budgets.
// ----------------------------------------------------------------------------
module tb_xmodem_crc_receiver;
    import xcrc_pkg::*;

    // Packet flaws the session generator can inject
    localparam int FLAW_NONE  = 0;
    localparam int FLAW_COMPL = 1;   // complement does not match sequence
    localparam int FLAW_CRC   = 2;   // one CRC bit flipped
    localparam int FLAW_CUT   = 3;   // packet stops early, sender goes quiet

    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx;
    } rx_request_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx;
        logic [7:0]  data;
        logic [9:0]  idx;
        logic [10:0] len;
        logic        last;
    } rx_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    // Requests waiting to be offered, results waiting to arrive
    rx_request_t pending[$];
    rx_result_t  due_results[$];

    int mismatches = 0;
    int queued     = 0;
    bit calm       = 1'b0;   // no idling on either side
    bit hold_arm   = 1'b0;   // start the long receiver hold-off
    bit rx_hold    = 1'b0;
    bit want_long  = 1'b0;   // make the next packet a 1024-byte one if it is a good one

    // Model copy of the receiver state and its retry budgets
    logic [7:0]  budget_start = 8'd15;
    logic [7:0]  budget_good  = 8'd10;
    phase_t      rx_phase     = PH_IDLE;
    logic [7:0]  exp_seq      = 8'd1;
    logic [7:0]  retries      = 8'd15;
    logic [7:0]  reply        = C_CRC_REQ;
    logic [10:0] pos          = '0;
    logic        long_blk     = 1'b0;
    logic [7:0]  seq_b        = '0;
    logic [7:0]  seq_c        = '0;
    logic [15:0] crc_run      = '0;
    logic [7:0]  crc_hi       = '0;

    xmodem_crc_receiver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] rx_byte
        .s_tuser   (s_tuser),    // [1:0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] tx_byte, [15:8] data_byte,
                                 // [25:16] data_index, [36:26] packet_length
        .m_tuser   (m_tuser),    // [2:0] kind
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        return r;
    endfunction

    function automatic void push_result(input kind_t k, input logic [7:0] tx,
                                        input logic [7:0] db, input logic [9:0] idx,
                                        input logic [10:0] len);
        rx_result_t r;
        r.kind = k;
        r.tx   = tx;
        r.data = db;
        r.idx  = idx;
        r.len  = len;
        r.last = 1'b0;
        due_results.push_back(r);
    endfunction

    // Advance the receiver model by one request and queue the results it causes
    task automatic receiver_step(input logic [1:0] op, input logic [7:0] b);
        int          n_before;
        logic        in_pkt;
        logic        ok;
        logic [7:0]  prev_seq;
        logic [10:0] blk_len;
        rx_result_t  tail;
        n_before = due_results.size();
        in_pkt   = (rx_phase >= PH_SEQ) && (rx_phase <= PH_CRCL);
        blk_len  = long_blk ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
        case (op)
            OP_START: begin
                // A restart drops an open packet first
                if (in_pkt)
                    push_result(K_DISCARD, 8'h00, 8'h00, '0, '0);
                exp_seq = 8'd1;
                retries = budget_start;
                reply   = C_CRC_REQ;
                pos     = '0;
                push_result(K_SEND, reply, 8'h00, '0, '0);
                rx_phase = PH_HEADER;
            end
            OP_BYTE: begin
                case (rx_phase)
                    PH_HEADER: begin
                        if (b == C_STX || b == C_SOH) begin
                            long_blk = (b == C_STX);
                            rx_phase = PH_SEQ;
                        end else if (b == C_EOT) begin
                            push_result(K_SEND, C_ACK, 8'h00, '0, '0);
                            push_result(K_SEND, C_ACK, 8'h00, '0, '0);
                            push_result(K_COMPLETE, 8'h00, 8'h00, '0, '0);
                            rx_phase = PH_IDLE;
                        end
                    end
                    PH_SEQ: begin
                        seq_b    = b;
                        rx_phase = PH_COMPL;
                    end
                    PH_COMPL: begin
                        seq_c    = b;
                        crc_run  = '0;
                        pos      = '0;
                        rx_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        push_result(K_DATA, 8'h00, b, pos[9:0], '0);
                        crc_run = crc16_step(crc_run, b);
                        pos     = pos + 11'd1;
                        if (pos >= blk_len)
                            rx_phase = PH_CRCH;
                    end
                    PH_CRCH: begin
                        crc_hi   = b;
                        rx_phase = PH_CRCL;
                    end
                    PH_CRCL: begin
                        ok       = (seq_b == ~seq_c) && ({crc_hi, b} == crc_run);
                        prev_seq = exp_seq - 8'd1;
                        if (ok && seq_b == prev_seq) begin
                            // Repeat of the last good packet: drop it but ACK
                            reply = C_ACK;
                            push_result(K_DISCARD, 8'h00, 8'h00, '0, '0);
                            push_result(K_SEND, reply, 8'h00, '0, '0);
                            rx_phase = PH_HEADER;
                        end else if (ok && seq_b == exp_seq) begin
                            exp_seq = exp_seq + 8'd1;
                            retries = budget_good;
                            reply   = C_ACK;
                            push_result(K_ACCEPT, 8'h00, 8'h00, '0, blk_len);
                            push_result(K_SEND, reply, 8'h00, '0, '0);
                            rx_phase = PH_HEADER;
                        end else begin
                            // Bad packet: NAK on the next timeout, flush until then
                            reply = C_NAK;
                            push_result(K_DISCARD, 8'h00, 8'h00, '0, '0);
                            rx_phase = PH_FLUSH;
                        end
                    end
                    default: ;
                endcase
            end
            OP_TIMEOUT: begin
                if (rx_phase != PH_IDLE) begin
                    if (in_pkt)
                        push_result(K_DISCARD, 8'h00, 8'h00, '0, '0);
                    // 8-bit counter: a zero budget wraps and does not abort
                    retries = retries - 8'd1;
                    if (retries == 8'd0) begin
                        push_result(K_SEND, C_CAN, 8'h00, '0, '0);
                        push_result(K_SEND, C_CAN, 8'h00, '0, '0);
                        push_result(K_SEND, C_CAN, 8'h00, '0, '0);
                        push_result(K_ABORT, 8'h00, 8'h00, '0, '0);
                        rx_phase = PH_IDLE;
                    end else begin
                        push_result(K_SEND, reply, 8'h00, '0, '0);
                        rx_phase = PH_HEADER;
                    end
                end
            end
            default: ;
        endcase
        // Mark the final result of this request
        if (due_results.size() > n_before) begin
            tail      = due_results.pop_back();
            tail.last = 1'b1;
            due_results.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued requests, idle at random, hold the request while
    // the block stalls. Predict results at the edge that takes a request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        rx_request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                receiver_step(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pending.size() > 0 && (calm || $urandom_range(99, 0) >= 19)) begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= nxt.rx;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result taken with the oldest prediction, and
    // stall the result channel at random or during the hold-off.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        rx_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d data 0x%0h",
                                              m_tuser, m_tdata));
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", 32'(m_tuser), 32'(want.kind));
                    check_field("tx_byte", 32'(m_tdata[7:0]), 32'(want.tx));
                    check_field("data_byte", 32'(m_tdata[15:8]), 32'(want.data));
                    check_field("data_index", 32'(m_tdata[25:16]), 32'(want.idx));
                    check_field("packet_length", 32'(m_tdata[36:26]), 32'(want.len));
                    check_field("last", 32'(m_tlast), 32'(want.last));
                end
            end
            m_tready <= !rx_hold && (calm || $urandom_range(99, 0) >= 19);
        end
    end

    // Long receiver hold-off: the sender keeps offering, the block fills up
    initial begin : receiver_hold
        wait (hold_arm);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Hard stop if the block hangs
    initial begin : watchdog
        #5_000_000;
        $display("** xmodem_crc_receiver: FAILED **");
        $finish;
    end

    task automatic offer(input logic [1:0] op, input logic [7:0] b);
        rx_request_t r;
        r.op = op;
        r.rx = b;
        pending.push_back(r);
        queued++;
    endtask

    // Queue one packet; a cut packet stops partway through the payload
    task automatic offer_packet(input logic [7:0] seq, input int flaw, input bit long_pkt);
        logic [15:0] crc;
        logic [7:0]  d;
        int          len;
        crc = '0;
        len = int'(long_pkt ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES);
        if (flaw == FLAW_CUT)
            len = $urandom_range(20, 0);
        offer(OP_BYTE, long_pkt ? C_STX : C_SOH);
        offer(OP_BYTE, seq);
        offer(OP_BYTE, (flaw == FLAW_COMPL) ? seq : ~seq);
        for (int i = 0; i < len; i++) begin
            d = 8'($urandom_range(255, 0));
            offer(OP_BYTE, d);
            crc = crc16_step(crc, d);
        end
        if (flaw != FLAW_CUT) begin
            if (flaw == FLAW_CRC)
                crc = crc ^ (16'h0001 << $urandom_range(15, 0));
            offer(OP_BYTE, crc[15:8]);
            offer(OP_BYTE, crc[7:0]);
        end
    endtask

    // One transfer: start, a few packets of mixed quality, mostly an EOT
    task automatic offer_session();
        logic [7:0] next_seq;
        logic [7:0] bad_seq;
        int         roll;
        bit         lp;
        offer(OP_START, 8'($urandom_range(255, 0)));
        next_seq = 8'd1;
        repeat ($urandom_range(4, 1)) begin
            roll      = $urandom_range(99, 0);
            lp        = want_long || ($urandom_range(19, 0) == 0);
            want_long = 1'b0;
            if (roll < 55) begin
                offer_packet(next_seq, FLAW_NONE, lp);
                next_seq = next_seq + 8'd1;
            end else if (roll < 65) begin
                offer_packet(next_seq - 8'd1, FLAW_NONE, 1'b0);
            end else if (roll < 85) begin
                case ($urandom_range(3, 0))
                    0: offer_packet(next_seq, FLAW_COMPL, 1'b0);
                    1: offer_packet(next_seq, FLAW_CRC, 1'b0);
                    2: begin
                        // neither the expected nor the previous sequence number
                        bad_seq = next_seq + 8'd1 + 8'($urandom_range(200, 0));
                        offer_packet(bad_seq, FLAW_NONE, 1'b0);
                    end
                    default: offer_packet(next_seq, FLAW_CUT, 1'b0);
                endcase
                // trailing line noise gets flushed, then the sender goes quiet
                repeat ($urandom_range(3, 0)) offer(OP_BYTE, 8'($urandom_range(255, 0)));
                offer(OP_TIMEOUT, 8'($urandom_range(255, 0)));
            end else begin
                case ($urandom_range(2, 0))
                    0: offer(OP_TIMEOUT, 8'($urandom_range(255, 0)));
                    1: offer(OP_BYTE, 8'($urandom_range(255, 5)));
                    default: offer(2'd3, 8'($urandom_range(255, 0)));
                endcase
            end
        end
        if ($urandom_range(9, 0) < 7)
            offer(OP_BYTE, C_EOT);
    endtask

    // Wait until everything is offered, taken and checked, then let the
    // pipeline run empty
    task automatic settle();
        do @(negedge aclk);
        while (pending.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    // Write one retry budget; the block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_RETRIES_AT_START)
            budget_start = val;
        else
            budget_good = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase();
        queued = 0;
        while (queued < 200)
            offer_session();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Start budget of one: the first timeout aborts
        write_reg(CFG_RETRIES_AT_START, 8'd1);
        write_reg(CFG_RETRIES_AFTER_OK, 8'd255);
        @(negedge aclk);

        // Idle receiver ignores bytes, timeouts and the unknown op
        offer(OP_BYTE, 8'hFF);
        offer(OP_TIMEOUT, 8'h00);
        offer(2'd3, 8'h00);
        // Unknown header byte and unknown op, then timeout -> CAN x3, abort
        offer(OP_START, 8'hFF);
        offer(OP_BYTE, 8'h00);
        offer(2'd3, 8'hFF);
        offer(OP_TIMEOUT, 8'hFF);
        // EOT ends the transfer
        offer(OP_START, 8'h00);
        offer(OP_BYTE, C_EOT);
        // Timeout inside a packet: discard, then abort
        offer(OP_START, 8'h00);
        offer(OP_BYTE, C_SOH);
        offer(OP_BYTE, 8'h01);
        offer(OP_BYTE, 8'hFE);
        offer(OP_TIMEOUT, 8'h00);
        // Restart with a packet open, in the sequence and complement states
        offer(OP_START, 8'h00);
        offer(OP_BYTE, C_STX);
        offer(OP_START, 8'h00);
        offer(OP_BYTE, C_SOH);
        offer(OP_BYTE, 8'h01);
        offer(OP_START, 8'h00);
        offer(OP_BYTE, C_EOT);
        settle();

        // Zero budget: the first timeout wraps the counter, no abort
        write_reg(CFG_RETRIES_AT_START, 8'd0);
        write_reg(CFG_RETRIES_AFTER_OK, 8'd1);
        @(negedge aclk);
        offer(OP_START, 8'h00);
        offer(OP_TIMEOUT, 8'h00);
        offer(OP_BYTE, C_EOT);
        // Random traffic: one timeout after a good packet aborts
        random_phase();
        settle();

        // Largest budgets, with a long receiver stall
        write_reg(CFG_RETRIES_AT_START, 8'd255);
        write_reg(CFG_RETRIES_AFTER_OK, 8'd255);
        @(negedge aclk);
        random_phase();
        hold_arm = 1'b1;
        settle();

        // Tight budgets, no idling, and the first packet a 1024-byte one if it is good
        write_reg(CFG_RETRIES_AT_START, 8'd3);
        write_reg(CFG_RETRIES_AFTER_OK, 8'd2);
        @(negedge aclk);
        calm      = 1'b1;
        want_long = 1'b1;
        random_phase();
        settle();

        if (mismatches == 0)
            $display("** xmodem_crc_receiver: PASSED **");
        else
            $display("** xmodem_crc_receiver: FAILED **");
        $finish;
    end

endmodule
